@@ rtl/xcrc_pkg.sv @@
package xcrc_pkg;

	// Block sizes in payload bytes
	localparam int unsigned LONG_BLOCK_BYTES  = 1024;
	localparam int unsigned SHORT_BLOCK_BYTES = 128;
	localparam int unsigned IDX_W             = 10;

	localparam logic [IDX_W-1:0] LONG_LAST  = IDX_W'(LONG_BLOCK_BYTES - 1);
	localparam logic [IDX_W-1:0] SHORT_LAST = IDX_W'(SHORT_BLOCK_BYTES - 1);

	// Link characters
	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_STX = 8'h02;
	localparam logic [7:0] CH_EOT = 8'h04;
	localparam logic [7:0] CH_ACK = 8'h06;
	localparam logic [7:0] CH_NAK = 8'h15;
	localparam logic [7:0] CH_CAN = 8'h18;
	localparam logic [7:0] CH_C   = 8'h43;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Request kinds
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// Verdict codes
	localparam logic [1:0] VD_NONE   = 2'd0;
	localparam logic [1:0] VD_COMMIT = 2'd1;
	localparam logic [1:0] VD_DUP    = 2'd2;
	localparam logic [1:0] VD_REJECT = 2'd3;

	// Status codes
	localparam logic [1:0] ST_RUNNING   = 2'd0;
	localparam logic [1:0] ST_DONE      = 2'd1;
	localparam logic [1:0] ST_CANCELLED = 2'd2;

	typedef enum logic [3:0] {
		PH_PROMPT,
		PH_WAITSTART,
		PH_HEADER,
		PH_BLKNO,
		PH_BLKINV,
		PH_DATA,
		PH_CRCHI,
		PH_CRCLO,
		PH_FINISHED
	} phase_t;

	typedef struct packed {
		logic             tx_valid;
		logic [7:0]       tx_byte;
		logic             data_valid;
		logic [7:0]       data_byte;
		logic [IDX_W-1:0] data_index;
		logic [1:0]       verdict;
		logic [1:0]       status;
	} result_t;

	// CRC-16/XMODEM update by one byte, MSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/xcrc_fsm.sv @@
module xcrc_fsm
	import xcrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        fire,
	input  logic        req_type,
	input  logic [7:0]  rx_byte,
	output logic        has_result,
	output result_t     res
);

	phase_t           phase_q, phase_d;
	logic             long_q, long_d;
	logic [IDX_W-1:0] count_q, count_d;
	logic [7:0]       rnum_q, rnum_d;
	logic [7:0]       expnum_q, expnum_d;
	logic [15:0]      crc_q, crc_d;
	logic [7:0]       crchi_q, crchi_d;
	logic [15:0]      timer_q, timer_d;
	logic [15:0]      timeout_q;

	logic             tick;
	logic [16:0]      timer_inc;
	logic [15:0]      limit;
	logic             timer_hit;
	logic [15:0]      crc_next;
	logic [IDX_W-1:0] last_idx;
	logic             is_last;
	logic             inv_ok;
	logic             crc_ok;
	logic             num_new;
	logic             num_dup;
	logic             is_header;

	// Decode helpers shared by next-state and output logic
	assign tick      = (req_type == REQ_TICK);
	assign timer_inc = {1'b0, timer_q} + 17'd1;
	assign limit     = (timeout_q == 16'd0) ? 16'd1 : timeout_q;
	assign timer_hit = (timer_inc >= {1'b0, limit});
	assign crc_next  = crc_byte(crc_q, rx_byte);
	assign last_idx  = long_q ? LONG_LAST : SHORT_LAST;
	assign is_last   = (count_q >= last_idx);
	assign inv_ok    = ((rnum_q ^ rx_byte) == 8'hFF);
	assign crc_ok    = ({crchi_q, rx_byte} == crc_q);
	assign num_new   = (rnum_q == expnum_q);
	assign num_dup   = (rnum_q == (expnum_q - 8'd1));
	assign is_header = (phase_q == PH_PROMPT) || (phase_q == PH_WAITSTART) ||
		(phase_q == PH_HEADER);

	// Timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 16'hFFFF;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	// Protocol state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PROMPT;
			long_q   <= 1'b0;
			count_q  <= '0;
			rnum_q   <= 8'd0;
			expnum_q <= 8'd1;
			crc_q    <= 16'd0;
			crchi_q  <= 8'd0;
			timer_q  <= 16'd0;
		end else begin
			phase_q  <= phase_d;
			long_q   <= long_d;
			count_q  <= count_d;
			rnum_q   <= rnum_d;
			expnum_q <= expnum_d;
			crc_q    <= crc_d;
			crchi_q  <= crchi_d;
			timer_q  <= timer_d;
		end
	end

	// Next state
	always_comb begin
		phase_d  = phase_q;
		long_d   = long_q;
		count_d  = count_q;
		rnum_d   = rnum_q;
		expnum_d = expnum_q;
		crc_d    = crc_q;
		crchi_d  = crchi_q;
		timer_d  = timer_q;
		if (fire && phase_q != PH_FINISHED) begin
			if (tick) begin
				case (phase_q)
					PH_PROMPT: begin
						phase_d = PH_WAITSTART;
						timer_d = 16'd0;
					end
					PH_HEADER: begin
						timer_d = timer_q;
					end
					PH_WAITSTART: begin
						timer_d = timer_hit ? 16'd0 : timer_inc[15:0];
					end
					default: begin
						timer_d = timer_hit ? 16'd0 : timer_inc[15:0];
						if (timer_hit) phase_d = PH_HEADER;
					end
				endcase
			end else begin
				timer_d = 16'd0;
				case (phase_q)
					PH_PROMPT, PH_WAITSTART, PH_HEADER: begin
						if (rx_byte == CH_EOT || rx_byte == CH_CAN) begin
							phase_d = PH_FINISHED;
						end else if (rx_byte == CH_SOH || rx_byte == CH_STX) begin
							long_d  = (rx_byte == CH_STX);
							phase_d = PH_BLKNO;
						end else begin
							phase_d = PH_HEADER;
						end
					end
					PH_BLKNO: begin
						rnum_d  = rx_byte;
						phase_d = PH_BLKINV;
					end
					PH_BLKINV: begin
						if (!inv_ok) begin
							phase_d = PH_HEADER;
						end else begin
							phase_d = PH_DATA;
							count_d = '0;
							crc_d   = 16'd0;
						end
					end
					PH_DATA: begin
						crc_d   = crc_next;
						count_d = count_q + IDX_W'(1);
						if (is_last) phase_d = PH_CRCHI;
					end
					PH_CRCHI: begin
						crchi_d = rx_byte;
						phase_d = PH_CRCLO;
					end
					PH_CRCLO: begin
						phase_d = PH_HEADER;
						if (crc_ok && num_new) expnum_d = expnum_q + 8'd1;
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
		end
	end

	// Result for the current request
	always_comb begin
		has_result = 1'b0;
		res        = '0;
		if (phase_q != PH_FINISHED) begin
			if (tick) begin
				case (phase_q)
					PH_PROMPT: begin
						has_result  = 1'b1;
						res.tx_valid = 1'b1;
						res.tx_byte  = CH_C;
					end
					PH_WAITSTART: begin
						if (timer_hit) begin
							has_result   = 1'b1;
							res.tx_valid = 1'b1;
							res.tx_byte  = CH_C;
						end
					end
					PH_HEADER: begin
						has_result = 1'b0;
					end
					default: begin
						if (timer_hit) begin
							has_result   = 1'b1;
							res.tx_valid = 1'b1;
							res.tx_byte  = CH_NAK;
							res.verdict  = (phase_q >= PH_DATA) ? VD_REJECT : VD_NONE;
						end
					end
				endcase
			end else if (is_header) begin
				has_result = 1'b1;
				if (rx_byte == CH_EOT) begin
					res.tx_valid = 1'b1;
					res.tx_byte  = CH_ACK;
					res.status   = ST_DONE;
				end else if (rx_byte == CH_CAN) begin
					res.status   = ST_CANCELLED;
				end else if (rx_byte == CH_SOH || rx_byte == CH_STX) begin
					has_result   = 1'b0;
				end else begin
					res.tx_valid = 1'b1;
					res.tx_byte  = CH_NAK;
				end
			end else begin
				case (phase_q)
					PH_BLKINV: begin
						if (!inv_ok) begin
							has_result   = 1'b1;
							res.tx_valid = 1'b1;
							res.tx_byte  = CH_NAK;
						end
					end
					PH_DATA: begin
						has_result     = 1'b1;
						res.data_valid = 1'b1;
						res.data_byte  = rx_byte;
						res.data_index = count_q;
					end
					PH_CRCLO: begin
						has_result   = 1'b1;
						res.tx_valid = 1'b1;
						if (crc_ok && num_new) begin
							res.tx_byte = CH_ACK;
							res.verdict = VD_COMMIT;
						end else if (crc_ok && num_dup) begin
							res.tx_byte = CH_ACK;
							res.verdict = VD_DUP;
						end else begin
							res.tx_byte = CH_NAK;
							res.verdict = VD_REJECT;
						end
					end
					default: begin
						has_result = 1'b0;
					end
				endcase
			end
		end
	end

endmodule

@@ rtl/xcrc_out_reg.sv @@
module xcrc_out_reg
	import xcrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  result_t     res,
	output logic        free,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser
);

	logic    valid_q;
	result_t res_q;

	assign free = !valid_q || m_axis_tready;

	// Hold a result until the downstream side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= res;
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tuser  = {res_q.data_valid, res_q.tx_valid};
	assign m_axis_tdata  = {2'b00, res_q.status, res_q.verdict, res_q.data_index,
		res_q.data_byte, res_q.tx_byte};

endmodule

@@ rtl/xmodem_crc_receiver_core.sv @@
// XMODEM-CRC receiver, 128-byte (SOH) and 1K (STX) blocks.
// Slave stream: one request per received serial byte (tuser = 0, byte in
// tdata) or per time tick (tuser = 1). Master stream: at most one result per
// request, carrying the reply byte to send ('C', ACK or NAK), a tentative
// payload byte with its index, the block verdict and the transfer status.
// Payload bytes go out as they arrive; the verdict at block end tells the
// user to commit or discard them.
// cfg_we/cfg_wdata load the silence timeout in ticks; write it only while
// no request is in flight.
// Throughput: one request per cycle while the master side does not stall. A
// request is held in the input register, the protocol step and CRC byte
// update run combinationally from it, and the registered result drives tvalid.
// When the master side stalls, the result register holds and the input
// register fills; tready drops only when both are full.
// Reset (arst_n low) returns to the prompting phase, expected block 1 and
// timeout 65535; pending requests and results are dropped.
module xmodem_crc_receiver_core
	import xcrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	input  logic        s_axis_tuser,  // [0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [7:0] tx_byte, [15:8] data_byte,
	                                   // [25:16] data_index, [27:26] verdict,
	                                   // [29:28] status, [31:30] zero
	output logic [1:0]  m_axis_tuser   // [0] tx_valid, [1] data_valid
);

	logic       valid_s1;
	logic       req_type_s1;
	logic [7:0] rx_byte_s1;
	logic       free;
	logic       advance;
	logic       has_result;
	result_t    res;

	assign advance       = valid_s1 && free;
	assign s_axis_tready = !valid_s1 || free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_type_s1 <= s_axis_tuser;
			rx_byte_s1  <= s_axis_tdata;
		end
	end

	xcrc_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fire       (advance),
		.req_type   (req_type_s1),
		.rx_byte    (rx_byte_s1),
		.has_result (has_result),
		.res        (res)
	);

	xcrc_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && has_result),
		.res           (res),
		.free          (free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

@@ rtl/xcrc_checker.sv @@
module xcrc_checker
	import xcrc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// A stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// A payload byte never comes with a reply or a verdict
	a_data_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |->
			!m_axis_tuser[0] && m_axis_tdata[27:26] == VD_NONE &&
			m_axis_tdata[29:28] == ST_RUNNING)
		else $error("payload byte mixed with reply");

	// End of transfer is acknowledged
	a_done_ack: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[29:28] == ST_DONE |->
			m_axis_tuser[0] && m_axis_tdata[7:0] == CH_ACK)
		else $error("transfer end without ACK");

	// A commit verdict always comes with ACK
	a_commit_ack: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[27:26] == VD_COMMIT |->
			m_axis_tuser[0] && m_axis_tdata[7:0] == CH_ACK)
		else $error("commit without ACK");

endmodule

bind xmodem_crc_receiver_core xcrc_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

@@ tb/sv/xmodem_rx_checker.sv @@
module xmodem_rx_checker
	import xcrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic        s_axis_tuser,   // [0] req_type
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,   // [7:0] tx_byte, [15:8] data_byte,
	                                    // [25:16] data_index, [27:26] verdict,
	                                    // [29:28] status
	input  logic [1:0]  m_axis_tuser,   // [0] tx_valid, [1] data_valid
	output int          replies_pending,
	output int          mismatch_count
);

	// Receiver state as the protocol defines it
	logic [15:0]      timeout_ticks;
	phase_t           phase;
	logic             long_block;
	logic [IDX_W-1:0] byte_count;
	logic [7:0]       rx_number;
	logic [7:0]       want_number;
	logic [15:0]      run_crc;
	logic [7:0]       crc_hi;
	logic [15:0]      silence;

	result_t          replies_due[$];
	result_t          due;

	// CRC-16/XMODEM, one message bit at a time, MSB first
	function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			c = (c[15] ^ b[i]) ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	// Advance the silence timer by one tick; report expiry and clear it
	function automatic bit silence_expired();
		logic [16:0] lim;
		logic [16:0] t;
		lim = (timeout_ticks == 16'd0) ? 17'd1 : {1'b0, timeout_ticks};
		t = {1'b0, silence} + 17'd1;
		if (t >= lim) begin
			silence = '0;
			return 1'b1;
		end
		silence = t[15:0];
		return 1'b0;
	endfunction

	function automatic result_t reply_of(input logic txv, input logic [7:0] txb, input logic dv,
			input logic [7:0] db, input logic [IDX_W-1:0] di, input logic [1:0] vd,
			input logic [1:0] st);
		result_t r;
		r.tx_valid   = txv;
		r.tx_byte    = txb;
		r.data_valid = dv;
		r.data_byte  = db;
		r.data_index = di;
		r.verdict    = vd;
		r.status     = st;
		return r;
	endfunction

	// Step the receiver by one request and queue the reply it causes
	task automatic xmodem_rx_step(input logic kind, input logic [7:0] b);
		result_t r;
		bit      hit;
		logic [1:0] vd;
		hit = 1'b0;
		r = '0;
		if (phase == PH_FINISHED) begin
			hit = 1'b0;
		end else if (kind == REQ_TICK) begin
			case (phase)
				PH_PROMPT: begin
					phase = PH_WAITSTART;
					silence = '0;
					r = reply_of(1'b1, CH_C, 1'b0, 8'h00, '0, VD_NONE, ST_RUNNING);
					hit = 1'b1;
				end
				PH_WAITSTART: begin
					if (silence_expired()) begin
						r = reply_of(1'b1, CH_C, 1'b0, 8'h00, '0, VD_NONE, ST_RUNNING);
						hit = 1'b1;
					end
				end
				PH_HEADER: begin
				end
				default: begin
					if (silence_expired()) begin
						vd = (phase >= PH_DATA) ? VD_REJECT : VD_NONE;
						phase = PH_HEADER;
						r = reply_of(1'b1, CH_NAK, 1'b0, 8'h00, '0, vd, ST_RUNNING);
						hit = 1'b1;
					end
				end
			endcase
		end else begin
			silence = '0;
			hit = 1'b1;
			case (phase)
				PH_PROMPT, PH_WAITSTART, PH_HEADER: begin
					if (b == CH_EOT) begin
						phase = PH_FINISHED;
						r = reply_of(1'b1, CH_ACK, 1'b0, 8'h00, '0, VD_NONE, ST_DONE);
					end else if (b == CH_CAN) begin
						phase = PH_FINISHED;
						r = reply_of(1'b0, 8'h00, 1'b0, 8'h00, '0, VD_NONE, ST_CANCELLED);
					end else if (b == CH_SOH || b == CH_STX) begin
						long_block = (b == CH_STX);
						phase = PH_BLKNO;
						hit = 1'b0;
					end else begin
						phase = PH_HEADER;
						r = reply_of(1'b1, CH_NAK, 1'b0, 8'h00, '0, VD_NONE, ST_RUNNING);
					end
				end
				PH_BLKNO: begin
					rx_number = b;
					phase = PH_BLKINV;
					hit = 1'b0;
				end
				PH_BLKINV: begin
					if ((rx_number ^ b) != 8'hFF) begin
						phase = PH_HEADER;
						r = reply_of(1'b1, CH_NAK, 1'b0, 8'h00, '0, VD_NONE, ST_RUNNING);
					end else begin
						phase = PH_DATA;
						byte_count = '0;
						run_crc = '0;
						hit = 1'b0;
					end
				end
				PH_DATA: begin
					run_crc = crc16_update(run_crc, b);
					r = reply_of(1'b0, 8'h00, 1'b1, b, byte_count, VD_NONE, ST_RUNNING);
					if (byte_count >= (long_block ? LONG_LAST : SHORT_LAST)) begin
						phase = PH_CRCHI;
					end
					byte_count = byte_count + 1'b1;
				end
				PH_CRCHI: begin
					crc_hi = b;
					phase = PH_CRCLO;
					hit = 1'b0;
				end
				default: begin
					phase = PH_HEADER;
					if ({crc_hi, b} != run_crc) begin
						r = reply_of(1'b1, CH_NAK, 1'b0, 8'h00, '0, VD_REJECT, ST_RUNNING);
					end else if (rx_number == want_number) begin
						want_number = want_number + 8'd1;
						r = reply_of(1'b1, CH_ACK, 1'b0, 8'h00, '0, VD_COMMIT, ST_RUNNING);
					end else if (rx_number == 8'(want_number - 8'd1)) begin
						r = reply_of(1'b1, CH_ACK, 1'b0, 8'h00, '0, VD_DUP, ST_RUNNING);
					end else begin
						r = reply_of(1'b1, CH_NAK, 1'b0, 8'h00, '0, VD_REJECT, ST_RUNNING);
					end
				end
			endcase
		end
		if (hit) begin
			replies_due.push_back(r);
		end
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// Retire replies against the oldest prediction, then predict new requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ticks   = 16'hFFFF;
			phase           = PH_PROMPT;
			long_block      = 1'b0;
			byte_count      = '0;
			rx_number       = 8'd0;
			want_number     = 8'd1;
			run_crc         = '0;
			crc_hi          = 8'd0;
			silence         = '0;
			replies_due.delete();
			replies_pending = 0;
			mismatch_count  = 0;
		end else begin
			if (cfg_we) begin
				timeout_ticks = cfg_wdata;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (replies_due.size() == 0) begin
					$error("unexpected reply: tdata 0x%h, tuser 0x%h", m_axis_tdata, m_axis_tuser);
					mismatch_count++;
				end else begin
					due = replies_due.pop_front();
					check_field("tx_valid", due.tx_valid, m_axis_tuser[0]);
					check_field("tx_byte", due.tx_byte, m_axis_tdata[7:0]);
					check_field("data_valid", due.data_valid, m_axis_tuser[1]);
					check_field("data_byte", due.data_byte, m_axis_tdata[15:8]);
					check_field("data_index", due.data_index, m_axis_tdata[25:16]);
					check_field("verdict", due.verdict, m_axis_tdata[27:26]);
					check_field("status", due.status, m_axis_tdata[29:28]);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				xmodem_rx_step(s_axis_tuser, s_axis_tdata);
			end
			replies_pending = replies_due.size();
		end
	end

endmodule

@@ tb/sv/tb.sv @@
module tb;
	import xcrc_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int SEG_REQUESTS = 40;

	typedef enum int {
		BLK_GOOD,
		BLK_BAD_INV,
		BLK_BAD_CRC,
		BLK_CUT
	} flaw_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic [15:0] cfg_wdata     = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;   // [7:0] rx_byte
	logic        s_axis_tuser  = 1'b0; // [0] req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;         // [7:0] tx_byte, [15:8] data_byte, [25:16] data_index,
	                                   // [27:26] verdict, [29:28] status
	logic [1:0]  m_axis_tuser;         // [0] tx_valid, [1] data_valid
	int          replies_pending;
	int          mismatch_count;

	int          send_idle_pct = 23;
	int          recv_idle_pct = 72;
	int          requests_sent = 0;
	int          quiet_cycles  = 0;
	int          tick_limit    = 65535;
	logic [7:0]  next_block    = 8'd1;
	bit          block_broken  = 1'b0;

	xmodem_crc_receiver_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	xmodem_rx_checker rx_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.replies_pending (replies_pending),
		.mismatch_count  (mismatch_count)
	);

	always #5 clk = ~clk;

	// Stall the reply side at random
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles++;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end else begin
			quiet_cycles = 0;
		end
	end

	// CRC-16/XMODEM of the sender side
	function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		repeat (8) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	// Offer one request, idling first at random; returns at the falling edge after acceptance
	task automatic send_req(input logic kind, input logic [7:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		requests_sent++;
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_req(REQ_TICK, 8'($urandom));
	endtask

	// Maybe pause inside a block; note when the pause is long enough to time out
	task automatic block_gap();
		int n;
		if ($urandom_range(999) < ((tick_limit > 4) ? 40 : 3)) begin
			n = $urandom_range(1, 4);
			if (n >= tick_limit) begin
				block_broken = 1'b1;
			end
			send_ticks(n);
		end
	endtask

	// Load the timeout once the block has drained
	task automatic set_timeout(input logic [15:0] v);
		s_axis_tvalid <= 1'b0;
		while (replies_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		tick_limit = (v == 16'd0) ? 1 : int'(v);
	endtask

	// Send one block; stop early once the receiver has left it
	task automatic send_block(input bit is_long, input logic [7:0] num, input flaw_t flaw);
		int          len;
		int          cut_at;
		logic [15:0] crc;
		logic [7:0]  b;
		len = is_long ? LONG_BLOCK_BYTES : SHORT_BLOCK_BYTES;
		cut_at = $urandom_range(0, len - 1);
		crc = '0;
		block_broken = 1'b0;
		send_req(REQ_BYTE, is_long ? CH_STX : CH_SOH);
		block_gap();
		if (!block_broken) begin
			send_req(REQ_BYTE, num);
			block_gap();
		end
		if (!block_broken) begin
			b = ~num;
			if (flaw == BLK_BAD_INV) begin
				b = b ^ (8'd1 << $urandom_range(7));
			end
			send_req(REQ_BYTE, b);
			if (flaw == BLK_BAD_INV) begin
				block_broken = 1'b1;
			end else begin
				block_gap();
			end
		end
		for (int i = 0; i < len && !block_broken; i++) begin
			if (flaw == BLK_CUT && i == cut_at) begin
				send_ticks(tick_limit);
				block_broken = 1'b1;
			end else begin
				b = ($urandom_range(9) == 0) ? {8{$urandom_range(1) == 1}} : 8'($urandom);
				crc = crc16_next(crc, b);
				send_req(REQ_BYTE, b);
				block_gap();
			end
		end
		if (!block_broken) begin
			if (flaw == BLK_BAD_CRC) begin
				crc = crc ^ (16'd1 << $urandom_range(15));
			end
			send_req(REQ_BYTE, crc[15:8]);
			block_gap();
		end
		if (!block_broken) begin
			send_req(REQ_BYTE, crc[7:0]);
			if (flaw == BLK_GOOD && num == next_block) begin
				next_block = next_block + 8'd1;
			end
		end
	endtask

	// Mostly blocks with random content, some header noise and idle ticks
	task automatic random_traffic(input int budget);
		int         stop_at;
		int         p;
		logic [7:0] num;
		logic [7:0] b;
		flaw_t      flaw;
		stop_at = requests_sent + budget;
		while (requests_sent < stop_at) begin
			p = $urandom_range(99);
			if (p < 8) begin
				do b = 8'($urandom);
				while (b == CH_SOH || b == CH_STX || b == CH_EOT || b == CH_CAN);
				send_req(REQ_BYTE, b);
			end else if (p < 14) begin
				send_ticks($urandom_range(1, 6));
			end else begin
				p = $urandom_range(99);
				num = (p < 80) ? next_block : (p < 90) ? 8'(next_block - 8'd1) : 8'($urandom);
				p = $urandom_range(99);
				if (p < 70) begin
					flaw = BLK_GOOD;
				end else if (p < 80) begin
					flaw = BLK_BAD_INV;
				end else if (p < 90 || tick_limit > 64) begin
					flaw = BLK_BAD_CRC;
				end else begin
					flaw = BLK_CUT;
				end
				send_block($urandom_range(99) < 2, num, flaw);
			end
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_timeout(16'd3);

		// Prompt on the first tick and again after three silent ticks, or start with a byte
		if ($urandom_range(1) == 1) begin
			send_ticks(4);
		end
		// Unknown header byte
		send_req(REQ_BYTE, 8'hFF);
		// Bad complement, then a stray byte taken as a header
		send_req(REQ_BYTE, CH_SOH);
		send_req(REQ_BYTE, 8'h01);
		send_req(REQ_BYTE, 8'h01);
		send_req(REQ_BYTE, 8'h80);
		// 1K block that goes silent inside the payload
		send_req(REQ_BYTE, CH_STX);
		send_req(REQ_BYTE, 8'h01);
		send_req(REQ_BYTE, 8'hFE);
		send_req(REQ_BYTE, 8'hFF);
		send_req(REQ_BYTE, 8'h00);
		send_ticks(3);
		// Silence before the payload starts
		send_req(REQ_BYTE, CH_SOH);
		send_req(REQ_BYTE, 8'h01);
		send_ticks(3);
		// Ticks while waiting for a header do nothing
		send_ticks(3);

		// Random traffic under several timeouts and idle patterns
		for (int seg = 0; seg < 6; seg++) begin
			case (seg)
				0: set_timeout(16'hFFFF);
				1: set_timeout(16'd1);
				2: set_timeout(16'd0);
				3: set_timeout(16'($urandom_range(2, 6)));
				4: set_timeout(16'($urandom_range(2, 40)));
				default: set_timeout(16'hFFFF);
			endcase
			if (seg == 2) begin
				send_idle_pct = 72;
				recv_idle_pct = 23;
			end else if (seg == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (seg == 0) begin
				send_block(1'b1, next_block, BLK_GOOD);
			end
			random_traffic(SEG_REQUESTS);
		end

		// Close the transfer; what follows is ignored
		send_req(REQ_BYTE, ($urandom_range(1) == 1) ? CH_EOT : CH_CAN);
		send_req(REQ_TICK, 8'($urandom));
		send_req(REQ_BYTE, CH_SOH);
		send_req(REQ_BYTE, 8'($urandom));
		s_axis_tvalid <= 1'b0;

		while (replies_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/xcrc_pkg.sv
rtl/xcrc_fsm.sv
rtl/xcrc_out_reg.sv
rtl/xmodem_crc_receiver_core.sv
rtl/xcrc_checker.sv
tb/sv/xmodem_rx_checker.sv
tb/sv/tb.sv
